// ----- hdl/xcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared constants and types of the XOR checked frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  // Number of burst bytes that are kept; later bytes are dropped.
  localparam int unsigned FrameKeep = 15;
  // Width of the position counter, which saturates at FrameKeep.
  localparam int unsigned PosW = $clog2(FrameKeep + 1);
  // Header byte expected at positions zero and one.
  localparam logic [7:0] HeaderMark = 8'hFF;
  // Position of the check byte, and the first data byte.
  localparam int unsigned CheckIndex = 14;
  localparam int unsigned DataFirst = 2;
  // First byte of each little-endian data word.
  localparam int unsigned LinXBase = 2;
  localparam int unsigned LinYBase = 6;
  localparam int unsigned AngBase = 10;

  typedef logic [7:0] byte_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [31:0] word_t;
  typedef byte_t [FrameKeep-1:0] frame_t;

  // Control of one accepted beat, shared by capture and check.
  typedef struct packed {
    logic take;
    logic last;
  } step_t;

  // Assemble a little-endian word from four frame bytes.
  function automatic word_t word_at(input frame_t f, input int unsigned base);
    word_at = {f[base + 3], f[base + 2], f[base + 1], f[base]};
  endfunction

endpackage

// ----- hdl/xcfp_in_if.sv -----
// ----------------------------------------------------------------------------
// xcfp_in_if
// Byte channel into the parser: one received byte and its end of burst flag.
// ----------------------------------------------------------------------------
interface xcfp_in_if;
  logic                 valid;
  logic                 ready;
  xcfp_pkg::byte_t      rx_byte;
  logic                 end_of_burst;

  modport source (output valid, output rx_byte, output end_of_burst, input ready);
  modport sink (input valid, input rx_byte, input end_of_burst, output ready);
endinterface

// ----- hdl/xcfp_out_if.sv -----
// ----------------------------------------------------------------------------
// xcfp_out_if
// Result channel of the parser: check flag and the three held words.
// ----------------------------------------------------------------------------
interface xcfp_out_if;
  logic                 valid;
  logic                 ready;
  logic                 frame_ok;
  xcfp_pkg::word_t      linear_x_word;
  xcfp_pkg::word_t      linear_y_word;
  xcfp_pkg::word_t      angular_word;

  modport source (output valid, output frame_ok, output linear_x_word,
                  output linear_y_word, output angular_word, input ready);
  modport sink (input valid, input frame_ok, input linear_x_word,
                input linear_y_word, input angular_word, output ready);
endinterface

// ----- hdl/xcfp_capture.sv -----
// ----------------------------------------------------------------------------
// xcfp_capture
// Byte position counter and frame byte registers. Presents the frame as it
// stands with the current beat merged in, and clears at the end of a burst.
// ----------------------------------------------------------------------------
module xcfp_capture (
  input  logic                clk,
  input  logic                rst,
  input  xcfp_pkg::step_t     step,
  input  xcfp_pkg::byte_t     rx_byte,
  output xcfp_pkg::frame_t    frame_view
);

  xcfp_pkg::pos_t   byte_position;
  xcfp_pkg::frame_t frame_store;
  logic             room;

  assign room = (byte_position < xcfp_pkg::pos_t'(xcfp_pkg::FrameKeep));

  // The current byte lands at the running position while there is room.
  always_comb begin
    for (int i = 0; i < xcfp_pkg::FrameKeep; i++) begin
      if (room && (byte_position == xcfp_pkg::pos_t'(i))) begin
        frame_view[i] = rx_byte;
      end else begin
        frame_view[i] = frame_store[i];
      end
    end
  end

  // Store the byte mid-burst; a burst end returns everything to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_store   <= '0;
    end else if (step.take) begin
      if (step.last) begin
        byte_position <= '0;
        frame_store   <= '0;
      end else if (room) begin
        frame_store[byte_position] <= rx_byte;
        byte_position              <= byte_position + 1'b1;
      end
    end
  end

  // A burst end always restarts the frame at position zero.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (step.take && step.last) |=> (byte_position == '0))
    else $error("position not cleared after burst end");

  // The position never passes the saturation point.
  a_saturate: assert property (@(posedge clk) disable iff (rst)
    (step.take && !step.last && !room) |=> (byte_position == $past(byte_position)))
    else $error("position moved while saturated");

endmodule

// ----- hdl/xcfp_check.sv -----
// ----------------------------------------------------------------------------
// xcfp_check
// Header and XOR check of a finished frame, held word registers and the
// result register that drives the output channel.
// ----------------------------------------------------------------------------
module xcfp_check (
  input  logic                clk,
  input  logic                rst,
  input  xcfp_pkg::step_t     step,
  input  xcfp_pkg::frame_t    frame_view,
  xcfp_out_if.source          res
);

  logic             header_ok;
  logic             sum_ok;
  logic             check_ok;
  xcfp_pkg::byte_t  sum;
  logic             res_valid;
  logic             frame_ok;
  xcfp_pkg::word_t  held_linear_x;
  xcfp_pkg::word_t  held_linear_y;
  xcfp_pkg::word_t  held_angular;

  // Header bytes and XOR over the data bytes against the check byte.
  always_comb begin
    sum = '0;
    for (int i = xcfp_pkg::DataFirst; i < xcfp_pkg::CheckIndex; i++) begin
      sum = sum ^ frame_view[i];
    end
    header_ok = (frame_view[0] == xcfp_pkg::HeaderMark) &&
                (frame_view[1] == xcfp_pkg::HeaderMark);
    sum_ok    = (sum == frame_view[xcfp_pkg::CheckIndex]);
    check_ok  = header_ok && sum_ok;
  end

  // Result register; held words load only from a frame that passed.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      frame_ok      <= 1'b0;
      held_linear_x <= '0;
      held_linear_y <= '0;
      held_angular  <= '0;
    end else begin
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      if (step.take && step.last) begin
        res_valid <= 1'b1;
        frame_ok  <= check_ok;
        if (check_ok) begin
          held_linear_x <= xcfp_pkg::word_at(frame_view, xcfp_pkg::LinXBase);
          held_linear_y <= xcfp_pkg::word_at(frame_view, xcfp_pkg::LinYBase);
          held_angular  <= xcfp_pkg::word_at(frame_view, xcfp_pkg::AngBase);
        end
      end
    end
  end

  assign res.valid         = res_valid;
  assign res.frame_ok      = frame_ok;
  assign res.linear_x_word = held_linear_x;
  assign res.linear_y_word = held_linear_y;
  assign res.angular_word  = held_angular;

  // Every burst end produces a pending result on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    (step.take && step.last) |=> res_valid)
    else $error("burst end gave no result");

  // Held words move only on a burst end.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !(step.take && step.last) |=> ($stable(held_linear_x) &&
      $stable(held_linear_y) && $stable(held_angular)))
    else $error("held words changed outside a burst end");

  // A failed check leaves the held words as they were.
  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
    (step.take && step.last && !check_ok) |=> (!frame_ok && $stable(held_angular)))
    else $error("failed frame changed the held words");

endmodule

// ----- hdl/xor_checked_frame_parser.sv -----
// ----------------------------------------------------------------------------
// xor_checked_frame_parser
// Frame parser with a header check and an XOR check over a burst of bytes.
//
//   channel  dir  payload                                        beats
//   rx       in   rx_byte[7:0], end_of_burst                      one per byte
//   res      out  frame_ok, linear_x/linear_y/angular_word[31:0]  one per burst
//
// One byte beat is taken per cycle while rx.ready is high; a burst end gives
// its result from the result register in the next cycle, and the next byte
// waits for res.ready. rx.ready drops only while a result is pending and
// res.ready is low, so the single result register sets the stall behavior.
// Reset (synchronous, active high) clears the position, frame bytes, held
// words and the pending result.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser (
  input  logic        clk,
  input  logic        rst,
  xcfp_in_if.sink     rx,
  xcfp_out_if.source  res
);

  xcfp_pkg::step_t  step;
  xcfp_pkg::frame_t frame_view;

  // Accept while the result register is free or being emptied.
  assign rx.ready  = !res.valid || res.ready;
  assign step.take = rx.valid && rx.ready;
  assign step.last = rx.end_of_burst;

  xcfp_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (rx.rx_byte),
    .frame_view (frame_view)
  );

  xcfp_check u_check (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .frame_view (frame_view),
    .res        (res)
  );

endmodule
